/* hdl/vrtb_pkg.sv */
// vrtb_pkg: shared types, register indexes and saturation helpers
// for the vertex rotate/translate/bounding-box block; no dependencies
`timescale 1ns / 1ps

package vrtb_pkg;

    localparam int POS_W   = 32;
    localparam int NORM_W  = 16;
    localparam int IDX_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int PROD_W  = ANGLE_W + POS_W;   // angle times position
    localparam int NPROD_W = ANGLE_W + NORM_W;  // angle times normal
    localparam int FRAC_W  = 14;                // Q2.14 angle fraction
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 3 * POS_W + 3 * NORM_W + IDX_W;
    localparam int M_TDATA_W  = 7 * POS_W + 3 * NORM_W + IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VERTEX = 3'd5;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    localparam logic [ANGLE_W-1:0] COS_RESET = 16'h4000;
    localparam logic [POS_W-1:0]   POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0]   POS_MIN   = 32'h8000_0000;
    localparam logic [NORM_W-1:0]  NORM_MAX  = 16'h7FFF;
    localparam logic [NORM_W-1:0]  NORM_MIN  = 16'h8000;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] cos_angle;
        logic signed [ANGLE_W-1:0] sin_angle;
        logic signed [POS_W-1:0]   offset_x;
        logic signed [POS_W-1:0]   offset_y;
        logic signed [POS_W-1:0]   offset_z;
        logic [IDX_W-1:0]          base_vertex;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [IDX_W-1:0]         index_in;
    } item_t;

    typedef struct packed {
        logic                      kind;
        logic signed [PROD_W-1:0]  cx;
        logic signed [PROD_W-1:0]  sy;
        logic signed [PROD_W-1:0]  sx;
        logic signed [PROD_W-1:0]  cy;
        logic signed [NPROD_W-1:0] ncx;
        logic signed [NPROD_W-1:0] nsy;
        logic signed [NPROD_W-1:0] nsx;
        logic signed [NPROD_W-1:0] ncy;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [NORM_W-1:0]  norm_z;
        logic [IDX_W-1:0]          index_in;
    } prod_t;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  out_x;
        logic [POS_W-1:0]  out_y;
        logic [POS_W-1:0]  out_z;
        logic [NORM_W-1:0] out_norm_x;
        logic [NORM_W-1:0] out_norm_y;
        logic [NORM_W-1:0] out_norm_z;
        logic [IDX_W-1:0]  index_out;
    } xform_t;

    typedef struct packed {
        logic [POS_W-1:0] min_x;
        logic [POS_W-1:0] min_y;
        logic [POS_W-1:0] max_x;
        logic [POS_W-1:0] max_y;
    } box_t;

    // clamp a 36-bit two's complement value to 32 bits
    function automatic logic [POS_W-1:0] sat_pos36(input logic [POS_W+3:0] v);
        logic [POS_W-1:0] r;
        if (v[POS_W+3:POS_W-1] == {5{v[POS_W+3]}}) begin
            r = v[POS_W-1:0];
        end else begin
            r = v[POS_W+3] ? POS_MIN : POS_MAX;
        end
        return r;
    endfunction

    // clamp a 33-bit two's complement value to 32 bits
    function automatic logic [POS_W-1:0] sat_pos33(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        if (v[POS_W] == v[POS_W-1]) begin
            r = v[POS_W-1:0];
        end else begin
            r = v[POS_W] ? POS_MIN : POS_MAX;
        end
        return r;
    endfunction

    // clamp a 19-bit two's complement value to 16 bits
    function automatic logic [NORM_W-1:0] sat_norm19(input logic [NORM_W+2:0] v);
        logic [NORM_W-1:0] r;
        if (v[NORM_W+2:NORM_W-1] == {4{v[NORM_W+2]}}) begin
            r = v[NORM_W-1:0];
        end else begin
            r = v[NORM_W+2] ? NORM_MIN : NORM_MAX;
        end
        return r;
    endfunction

endpackage

/* hdl/vrtb_rotate_mul.sv */
// vrtb_rotate_mul: rotation products of position and normal by cos/sin
// depends on vrtb_pkg
`timescale 1ns / 1ps

module vrtb_rotate_mul
    import vrtb_pkg::*;
(
    input  item_t item,
    input  cfg_t  cfg,
    output prod_t prod
);

    always_comb begin
        prod.kind     = item.kind;
        prod.cx       = cfg.cos_angle * item.pos_x;
        prod.sy       = cfg.sin_angle * item.pos_y;
        prod.sx       = cfg.sin_angle * item.pos_x;
        prod.cy       = cfg.cos_angle * item.pos_y;
        prod.ncx      = cfg.cos_angle * item.norm_x;
        prod.nsy      = cfg.sin_angle * item.norm_y;
        prod.nsx      = cfg.sin_angle * item.norm_x;
        prod.ncy      = cfg.cos_angle * item.norm_y;
        prod.pos_z    = item.pos_z;
        prod.norm_z   = item.norm_z;
        prod.index_in = item.index_in;
    end

endmodule

/* hdl/vrtb_round_sat.sv */
// vrtb_round_sat: sums the products, rounds, translates and saturates;
// index items get base_vertex added instead; depends on vrtb_pkg
`timescale 1ns / 1ps

module vrtb_round_sat
    import vrtb_pkg::*;
(
    input  prod_t  prod,
    input  cfg_t   cfg,
    output xform_t xf
);

    logic signed [PROD_W:0]   sum_x;
    logic signed [PROD_W:0]   sum_y;
    logic signed [NPROD_W:0]  sum_nx;
    logic signed [NPROD_W:0]  sum_ny;
    logic [POS_W+3:0]         trans_x;
    logic [POS_W+3:0]         trans_y;
    logic [POS_W:0]           trans_z;

    always_comb begin
        // round half up: add half an lsb, then drop the fraction bits
        sum_x  = (PROD_W+1)'(prod.cx) - (PROD_W+1)'(prod.sy) + (PROD_W+1)'(8192);
        sum_y  = (PROD_W+1)'(prod.sx) + (PROD_W+1)'(prod.cy) + (PROD_W+1)'(8192);
        sum_nx = (NPROD_W+1)'(prod.ncx) - (NPROD_W+1)'(prod.nsy) + (NPROD_W+1)'(8192);
        sum_ny = (NPROD_W+1)'(prod.nsx) + (NPROD_W+1)'(prod.ncy) + (NPROD_W+1)'(8192);

        trans_x = {sum_x[PROD_W], sum_x[PROD_W:FRAC_W]}
                + {{4{cfg.offset_x[POS_W-1]}}, cfg.offset_x};
        trans_y = {sum_y[PROD_W], sum_y[PROD_W:FRAC_W]}
                + {{4{cfg.offset_y[POS_W-1]}}, cfg.offset_y};
        trans_z = {prod.pos_z[POS_W-1], prod.pos_z}
                + {cfg.offset_z[POS_W-1], cfg.offset_z};

        xf.kind = prod.kind;
        if (prod.kind == KIND_INDEX) begin
            xf.out_x      = '0;
            xf.out_y      = '0;
            xf.out_z      = '0;
            xf.out_norm_x = '0;
            xf.out_norm_y = '0;
            xf.out_norm_z = '0;
            xf.index_out  = prod.index_in + cfg.base_vertex;
        end else begin
            xf.out_x      = sat_pos36(trans_x);
            xf.out_y      = sat_pos36(trans_y);
            xf.out_z      = sat_pos33(trans_z);
            xf.out_norm_x = sat_norm19(sum_nx[NPROD_W:FRAC_W]);
            xf.out_norm_y = sat_norm19(sum_ny[NPROD_W:FRAC_W]);
            xf.out_norm_z = prod.norm_z;
            xf.index_out  = '0;
        end
    end

endmodule

/* hdl/vrtb_bbox.sv */
// vrtb_bbox: running xy bounding box of transformed vertex positions
// depends on vrtb_pkg
`timescale 1ns / 1ps

module vrtb_bbox
    import vrtb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             upd_en,
    input  logic [POS_W-1:0] x,
    input  logic [POS_W-1:0] y,
    output box_t             box_next
);

    box_t box_reg;

    always_comb begin
        box_next = box_reg;
        if (upd_en) begin
            if ($signed(x) < $signed(box_reg.min_x)) begin
                box_next.min_x = x;
            end
            if ($signed(y) < $signed(box_reg.min_y)) begin
                box_next.min_y = y;
            end
            if ($signed(x) > $signed(box_reg.max_x)) begin
                box_next.max_x = x;
            end
            if ($signed(y) > $signed(box_reg.max_y)) begin
                box_next.max_y = y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg.min_x <= POS_MAX;
            box_reg.min_y <= POS_MAX;
            box_reg.max_x <= POS_MIN;
            box_reg.max_y <= POS_MIN;
        end else begin
            box_reg <= box_next;
        end
    end

endmodule

/* hdl/vertex_rotate_translate_bbox.sv */
// vertex_rotate_translate_bbox: top level, config registers and pipeline
// depends on vrtb_pkg, vrtb_rotate_mul, vrtb_round_sat, vrtb_bbox
`timescale 1ns / 1ps
//
// usage
//   s_ channel takes one vertex or index beat (s_tuser: 0 vertex, 1 index),
//   m_ channel returns one result beat per input beat, in order
//   vertex: rotate about z by cos/sin (q2.14), translate by offset (q16.16),
//   normal rotated only; index: base_vertex added, wraps at 16 bits
//   every result carries the running xy bounding box including that beat
//   config: cfg_wr_en with cfg_index/cfg_data, write only while idle
// timing
//   four register stages: input, products, rounded/saturated, output
//   an accepted beat moves through these stages in that order
//   one beat per cycle unless stalled; the multiplier stage sets cycle time
// reset
//   pipeline emptied, registers back to cos 1.0 and zero elsewhere, box empty
//   (min at most positive, max at most negative value)
// stall
//   while m_tready is low and a result waits, the whole pipeline holds and
//   s_tready drops; bubbles already inside the pipeline stay where they are
//
module vertex_rotate_translate_bbox
    import vrtb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, index_in
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z, out_norm_x, out_norm_y, out_norm_z, index_out,
    // box_min_x, box_min_y, box_max_x, box_max_y
    output logic [M_TDATA_W-1:0]  m_tdata
);

    cfg_t   cfg_reg;
    logic   s1_valid_reg;
    item_t  s1_reg;
    logic   s2_valid_reg;
    prod_t  s2_reg;
    logic   s3_valid_reg;
    xform_t s3_reg;
    logic   m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    item_t  item_in;
    prod_t  prod_next;
    xform_t xf_next;
    box_t   box_next;
    logic   advance;
    logic   box_upd;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_angle   <= COS_RESET;
            cfg_reg.sin_angle   <= '0;
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
            cfg_reg.offset_z    <= '0;
            cfg_reg.base_vertex <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COS_ANGLE:   cfg_reg.cos_angle   <= cfg_data[ANGLE_W-1:0];
                REG_SIN_ANGLE:   cfg_reg.sin_angle   <= cfg_data[ANGLE_W-1:0];
                REG_OFFSET_X:    cfg_reg.offset_x    <= cfg_data[POS_W-1:0];
                REG_OFFSET_Y:    cfg_reg.offset_y    <= cfg_data[POS_W-1:0];
                REG_OFFSET_Z:    cfg_reg.offset_z    <= cfg_data[POS_W-1:0];
                REG_BASE_VERTEX: cfg_reg.base_vertex <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        item_in.kind     = s_tuser[0];
        item_in.pos_x    = s_tdata[31:0];
        item_in.pos_y    = s_tdata[63:32];
        item_in.pos_z    = s_tdata[95:64];
        item_in.norm_x   = s_tdata[111:96];
        item_in.norm_y   = s_tdata[127:112];
        item_in.norm_z   = s_tdata[143:128];
        item_in.index_in = s_tdata[159:144];
    end

    vrtb_rotate_mul u_mul (
        .item (s1_reg),
        .cfg  (cfg_reg),
        .prod (prod_next)
    );

    vrtb_round_sat u_rsat (
        .prod (s2_reg),
        .cfg  (cfg_reg),
        .xf   (xf_next)
    );

    assign box_upd = advance && s3_valid_reg && (s3_reg.kind == KIND_VERTEX);

    vrtb_bbox u_bbox (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd_en   (box_upd),
        .x        (s3_reg.out_x),
        .y        (s3_reg.out_y),
        .box_next (box_next)
    );

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_reg     <= item_in;
            s2_reg     <= prod_next;
            s3_reg     <= xf_next;
            m_data_reg <= {box_next.max_y, box_next.max_x,
                           box_next.min_y, box_next.min_x,
                           s3_reg.index_out, s3_reg.out_norm_z,
                           s3_reg.out_norm_y, s3_reg.out_norm_x,
                           s3_reg.out_z, s3_reg.out_y, s3_reg.out_x};
        end
    end

endmodule

/* hdl/vrtb_checker.sv */
// vrtb_checker: port-level assertions for the top level, bound to it here
// depends on vrtb_pkg and vertex_rotate_translate_bbox
`timescale 1ns / 1ps

module vrtb_checker
    import vrtb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic geom_nonzero;
    logic box_x_set;
    logic box_y_set;

    assign geom_nonzero = (m_tdata[95:0] != '0) || (m_tdata[143:96] != '0);
    assign box_x_set = $signed(m_tdata[191:160]) <= $signed(m_tdata[255:224]);
    assign box_y_set = $signed(m_tdata[223:192]) <= $signed(m_tdata[287:256]);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_kind_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && geom_nonzero |-> m_tdata[159:144] == '0)
        else $error("vertex result carries an index");

    a_box_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> box_x_set == box_y_set)
        else $error("bounding box x and y disagree on emptiness");

    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

endmodule

bind vertex_rotate_translate_bbox vrtb_checker u_vrtb_checker (.*);
